// ----- src/rrsp_pkg.sv -----
`timescale 1ns / 1ps

package rrsp_pkg;

    localparam int MAX_DEPTH   = 8;
    localparam int LENGTH_BITS = 32;
    localparam int SP_W        = $clog2(MAX_DEPTH + 1);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_STR     = 4'd1,
        PH_STR_LF  = 4'd2,
        PH_ERR     = 4'd3,
        PH_ERR_LF  = 4'd4,
        PH_INT     = 4'd5,
        PH_INT_LF  = 4'd6,
        PH_BLEN    = 4'd7,
        PH_BLEN_LF = 4'd8,
        PH_BDATA   = 4'd9,
        PH_BCR     = 4'd10,
        PH_BLF     = 4'd11,
        PH_ALEN    = 4'd12,
        PH_ALEN_LF = 4'd13
    } phase_t;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_PAYLOAD = 4'd1,
        EV_STRING  = 4'd2,
        EV_ERRSTR  = 4'd3,
        EV_INTEGER = 4'd4,
        EV_BULK    = 4'd5,
        EV_NIL     = 4'd6,
        EV_ARRAY   = 4'd7,
        EV_EMPTY   = 4'd8,
        EV_PROTO   = 4'd9
    } event_t;

    // parser -> stack
    typedef struct packed {
        logic                   clear;
        logic                   push;
        logic                   close;
        logic [LENGTH_BITS-1:0] count;
    } stack_cmd_t;

    // stack -> parser / output stage
    typedef struct packed {
        logic            full;
        logic [SP_W-1:0] closed;
        logic [SP_W-1:0] sp_next;
    } stack_stat_t;

endpackage

// ----- src/rrsp_stack.sv -----
`timescale 1ns / 1ps

module rrsp_stack
    import rrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  stack_cmd_t  cmd,
    output stack_stat_t stat
);

    logic [LENGTH_BITS-1:0] level_reg [MAX_DEPTH];
    logic [SP_W-1:0]        sp_reg;

    logic [MAX_DEPTH:0]   inrun;
    logic [MAX_DEPTH-1:0] dec;
    logic [SP_W-1:0]      closed;
    logic [SP_W-1:0]      sp_next;

    // Levels at the top of the stack that hold exactly one element left all
    // close together; the first level below that run is decremented.
    always_comb begin
        inrun[MAX_DEPTH] = 1'b0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            inrun[i] = (SP_W'(i) < sp_reg) && (level_reg[i] == LENGTH_BITS'(1)) &&
                       ((SP_W'(i + 1) == sp_reg) || inrun[i + 1]);
        end
        for (int i = 0; i < MAX_DEPTH; i++) begin
            dec[i] = (SP_W'(i) < sp_reg) && !inrun[i] &&
                     ((SP_W'(i + 1) == sp_reg) || inrun[i + 1]);
        end
        closed = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            closed = closed + SP_W'(inrun[i]);
        end
    end

    always_comb begin
        sp_next = sp_reg;
        if (cmd.clear) begin
            sp_next = '0;
        end else if (cmd.push) begin
            sp_next = sp_reg + SP_W'(1);
        end else if (cmd.close) begin
            sp_next = sp_reg - closed;
        end
        stat.full    = (sp_reg == SP_W'(MAX_DEPTH));
        stat.closed  = cmd.close ? closed : '0;
        stat.sp_next = sp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (fire) begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && !cmd.clear) begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
                if (cmd.push && SP_W'(i) == sp_reg) begin
                    level_reg[i] <= cmd.count;
                end else if (cmd.close && dec[i]) begin
                    level_reg[i] <= level_reg[i] - LENGTH_BITS'(1);
                end
            end
        end
    end

endmodule

// ----- src/rrsp_parser.sv -----
`timescale 1ns / 1ps

module rrsp_parser
    import rrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic        stack_full,
    output event_t      kind,
    output logic [7:0]  payload,
    output logic [63:0] value,
    output stack_cmd_t  cmd
);

    phase_t                 phase_reg, phase_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   digits_reg, digits_next;
    logic [LENGTH_BITS-1:0] bulk_reg, bulk_next;

    logic [63:0] final_val;
    logic [63:0] acc_mul;
    logic        is_digit;
    logic        too_big;
    logic        num_err;
    logic        num_end;

    always_comb begin
        final_val = neg_reg ? (64'd0 - acc_reg) : acc_reg;
        acc_mul   = (acc_reg << 3) + (acc_reg << 1) + {60'd0, data_byte[3:0]};
        is_digit  = data_byte inside {[CH_0:CH_9]};
        too_big   = final_val[63] || (final_val[63:LENGTH_BITS] != '0);
        num_end   = (data_byte == CH_CR) && (digits_reg || neg_reg);
        num_err   = !is_digit && !(data_byte == CH_MINUS && !digits_reg && !neg_reg) &&
                    !num_end;
    end

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        digits_next = digits_reg;
        bulk_next   = bulk_reg;
        kind        = EV_NONE;
        payload     = 8'd0;
        value       = 64'd0;
        cmd         = '0;

        case (phase_reg)
            PH_START: begin
                acc_next    = 64'd0;
                neg_next    = 1'b0;
                digits_next = 1'b0;
                case (data_byte)
                    CH_PLUS:   phase_next = PH_STR;
                    CH_MINUS:  phase_next = PH_ERR;
                    CH_COLON:  phase_next = PH_INT;
                    CH_DOLLAR: phase_next = PH_BLEN;
                    CH_STAR:   phase_next = PH_ALEN;
                    default:   kind = EV_PROTO;
                endcase
            end
            PH_STR, PH_ERR: begin
                if (data_byte == CH_CR) begin
                    phase_next = (phase_reg == PH_STR) ? PH_STR_LF : PH_ERR_LF;
                end else if (data_byte inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
                    kind    = EV_PAYLOAD;
                    payload = data_byte;
                end else begin
                    kind = EV_PROTO;
                end
            end
            PH_STR_LF, PH_ERR_LF: begin
                if (data_byte == CH_LF) begin
                    kind       = (phase_reg == PH_STR_LF) ? EV_STRING : EV_ERRSTR;
                    phase_next = PH_START;
                end else begin
                    kind = EV_PROTO;
                end
            end
            PH_INT, PH_BLEN, PH_ALEN: begin
                if (is_digit) begin
                    acc_next    = acc_mul;
                    digits_next = 1'b1;
                end else if (num_err) begin
                    kind = EV_PROTO;
                end else if (num_end) begin
                    case (phase_reg)
                        PH_INT:  phase_next = PH_INT_LF;
                        PH_BLEN: phase_next = PH_BLEN_LF;
                        default: phase_next = PH_ALEN_LF;
                    endcase
                end else begin
                    neg_next = 1'b1;
                end
            end
            PH_INT_LF: begin
                if (data_byte == CH_LF) begin
                    kind       = EV_INTEGER;
                    value      = final_val;
                    phase_next = PH_START;
                end else begin
                    kind = EV_PROTO;
                end
            end
            PH_BLEN_LF: begin
                if (data_byte != CH_LF) begin
                    kind = EV_PROTO;
                end else if (final_val == '1) begin
                    kind       = EV_NIL;
                    value      = final_val;
                    phase_next = PH_START;
                end else if (too_big) begin
                    kind = EV_PROTO;
                end else begin
                    acc_next   = final_val;
                    neg_next   = 1'b0;
                    bulk_next  = final_val[LENGTH_BITS-1:0];
                    phase_next = (final_val == 64'd0) ? PH_BCR : PH_BDATA;
                end
            end
            PH_BDATA: begin
                kind      = EV_PAYLOAD;
                payload   = data_byte;
                bulk_next = bulk_reg - LENGTH_BITS'(1);
                if (bulk_reg == LENGTH_BITS'(1)) begin
                    phase_next = PH_BCR;
                end
            end
            PH_BCR: begin
                if (data_byte == CH_CR) begin
                    phase_next = PH_BLF;
                end else begin
                    kind = EV_PROTO;
                end
            end
            PH_BLF: begin
                if (data_byte == CH_LF) begin
                    kind       = EV_BULK;
                    value      = acc_reg;
                    phase_next = PH_START;
                end else begin
                    kind = EV_PROTO;
                end
            end
            PH_ALEN_LF: begin
                if (data_byte != CH_LF) begin
                    kind = EV_PROTO;
                end else if (final_val == '1 || final_val == 64'd0) begin
                    kind       = EV_EMPTY;
                    value      = final_val;
                    phase_next = PH_START;
                end else if (too_big || stack_full) begin
                    kind = EV_PROTO;
                end else begin
                    kind       = EV_ARRAY;
                    value      = final_val;
                    cmd.push   = 1'b1;
                    cmd.count  = final_val[LENGTH_BITS-1:0];
                    phase_next = PH_START;
                end
            end
            default: begin
                kind = EV_PROTO;
            end
        endcase

        if (kind == EV_PROTO) begin
            phase_next  = PH_START;
            acc_next    = 64'd0;
            neg_next    = 1'b0;
            digits_next = 1'b0;
            bulk_next   = '0;
            value       = 64'd0;
            payload     = 8'd0;
            cmd         = '0;
            cmd.clear   = 1'b1;
        end else begin
            cmd.close = (kind == EV_STRING) || (kind == EV_ERRSTR) ||
                        (kind == EV_INTEGER) || (kind == EV_BULK) ||
                        (kind == EV_NIL) || (kind == EV_EMPTY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            acc_reg    <= 64'd0;
            neg_reg    <= 1'b0;
            digits_reg <= 1'b0;
            bulk_reg   <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            digits_reg <= digits_next;
            bulk_reg   <= bulk_next;
        end
    end

endmodule

// ----- src/resp_reply_stream_parser.sv -----
`timescale 1ns / 1ps

// Reply stream parser: one byte in, one event out.
//
// Input channel s_*: one raw reply byte per transaction in s_tdata[7:0].
// Output channel m_*: one event per input byte. m_tuser carries the event
// kind, m_tlast is high when a complete top-level reply ends on that byte,
// m_tdata carries the payload byte, the number value, the open array depth
// and the count of arrays closed by the byte.
//
// An accepted byte goes into the input register, then through the parse
// logic into the output register. Throughput is one byte per cycle while
// m_tready takes each event, set by the state update (phase, decimal
// accumulator, array level stack).
//
// Synchronous active-low reset returns the parser to expecting a type byte
// with no arrays open and empties both registers. When m_tready is low the
// output register holds its event; one more byte is taken into the input
// register, then s_tready drops until the event is taken.
module resp_reply_stream_parser
    import rrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] payload_byte, [71:8] number_value,
                                   // [75:72] nest_depth, [79:76] arrays_closed
    output logic [3:0]  m_tuser,   // [3:0] event_kind
    output logic        m_tlast    // reply_done
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    event_t      kind;
    logic [7:0]  payload;
    logic [63:0] value;
    stack_cmd_t  cmd;
    stack_stat_t stat;

    logic        out_valid_reg;
    logic [3:0]  kind_reg;
    logic [7:0]  payload_reg;
    logic [63:0] value_reg;
    logic [3:0]  depth_reg;
    logic [3:0]  closed_reg;
    logic        done_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    rrsp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .data_byte  (in_byte_reg),
        .stack_full (stat.full),
        .kind       (kind),
        .payload    (payload),
        .value      (value),
        .cmd        (cmd)
    );

    rrsp_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .cmd     (cmd),
        .stat    (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg    <= kind;
            payload_reg <= payload;
            value_reg   <= value;
            depth_reg   <= 4'(stat.sp_next);
            closed_reg  <= 4'(stat.closed);
            done_reg    <= cmd.close && (stat.sp_next == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {closed_reg, depth_reg, value_reg, payload_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = done_reg;

endmodule
